>>> hdl/rtsp_response_header_parser_assert.svh
// ----------------------------------------------------------------------------
// RTSP response header parser assertion macros
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RTSP_RESPONSE_HEADER_PARSER_ASSERT_SVH
`define RTSP_RESPONSE_HEADER_PARSER_ASSERT_SVH

// The condition post holds in every cycle in which pre holds.
`define RRHP_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("rtsp header parser: implication check failed");

// The condition post holds in the cycle after one in which pre holds.
`define RRHP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rtsp header parser: next-cycle check failed");

`endif

>>> hdl/rrhp_pkg.sv
// ----------------------------------------------------------------------------
// RTSP response header parser package
// Defaults, character codes, key tables and small helper functions.
// ----------------------------------------------------------------------------
package rrhp_pkg;

    localparam int DEF_HEADER_LIMIT   = 1536;
    localparam int DEF_SESSION_ID_CAP = 64;

    localparam int BYTE_W     = 8;
    localparam int NUM_W      = 32;
    localparam int EXP_SEQ_W  = 31;
    localparam int BODY_LIM_W = 16;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int SID_OUT_W  = 6;
    localparam int KEY_NUM    = 4;
    localparam int KPOS_W     = 5;
    localparam int TM_W       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQUENCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_LIMIT        = 1'd1;

    localparam logic [EXP_SEQ_W-1:0]  EXP_SEQ_RST    = 31'd1;
    localparam logic [BODY_LIM_W-1:0] BODY_LIMIT_RST = 16'd2048;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LC_I  = 8'h69;
    localparam logic [BYTE_W-1:0] CH_LC_T  = 8'h74;

    localparam logic [1:0] KEY_IDX_CSEQ = 2'd0;
    localparam logic [1:0] KEY_IDX_AUTH = 2'd1;
    localparam logic [1:0] KEY_IDX_SESS = 2'd2;
    localparam logic [1:0] KEY_IDX_CLEN = 2'd3;

    localparam logic [KEY_NUM-1:0] KEY_NONE = 4'b0000;
    localparam logic [KEY_NUM-1:0] KEY_CSEQ = 4'b0001;
    localparam logic [KEY_NUM-1:0] KEY_AUTH = 4'b0010;
    localparam logic [KEY_NUM-1:0] KEY_SESS = 4'b0100;
    localparam logic [KEY_NUM-1:0] KEY_CLEN = 4'b1000;
    localparam logic [KEY_NUM-1:0] KEY_ALL  = 4'b1111;

    // Lower-case key names, left aligned and padded to 16 characters.
    localparam logic [127:0] KEY_TXT_CSEQ = "cseq            ";
    localparam logic [127:0] KEY_TXT_AUTH = "www-authenticate";
    localparam logic [127:0] KEY_TXT_SESS = "session         ";
    localparam logic [127:0] KEY_TXT_CLEN = "content-length  ";
    localparam logic [63:0]  TMO_TXT      = "timeout=";

    // Timeout matcher codes; values between scan and digits count matched characters.
    localparam logic [TM_W-1:0] TM_SID    = 4'd0;
    localparam logic [TM_W-1:0] TM_SCAN   = 4'd1;
    localparam logic [TM_W-1:0] TM_DIGITS = 4'd9;
    localparam logic [TM_W-1:0] TM_DONE   = 4'd10;

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        return (c >= CH_UC_A && c <= CH_UC_Z) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic [KPOS_W-1:0] key_len(input logic [1:0] k);
        logic [KPOS_W-1:0] len;
        case (k)
            KEY_IDX_CSEQ: len = 5'd4;
            KEY_IDX_AUTH: len = 5'd16;
            KEY_IDX_SESS: len = 5'd7;
            default:      len = 5'd14;
        endcase
        return len;
    endfunction

    function automatic logic [BYTE_W-1:0] key_char(input logic [1:0] k, input logic [3:0] p);
        logic [127:0] txt;
        case (k)
            KEY_IDX_CSEQ: txt = KEY_TXT_CSEQ;
            KEY_IDX_AUTH: txt = KEY_TXT_AUTH;
            KEY_IDX_SESS: txt = KEY_TXT_SESS;
            default:      txt = KEY_TXT_CLEN;
        endcase
        return txt[{~p, 3'b000} +: 8];
    endfunction

    function automatic logic [BYTE_W-1:0] tmo_char(input logic [2:0] k);
        return TMO_TXT[{~k, 3'b000} +: 8];
    endfunction

    // Appends one decimal digit, saturating at all ones.
    function automatic logic [NUM_W-1:0] acc_digit(input logic [NUM_W-1:0] a,
                                                   input logic [BYTE_W-1:0] c);
        logic [NUM_W+3:0] v;
        v = ({4'b0000, a} << 3) + ({4'b0000, a} << 1) + {32'd0, c[3:0]};
        return (|v[NUM_W+3:NUM_W]) ? '1 : v[NUM_W-1:0];
    endfunction

endpackage

>>> hdl/rtsp_response_header_parser.sv
// ----------------------------------------------------------------------------
// RTSP response header parser
// Scans an RTSP response byte stream and reports the parsed header fields.
// ----------------------------------------------------------------------------
// The input channel (i_valid, o_ready, i_byte_in) takes one byte of the
// response stream per item. The output channel (o_valid, i_ready and the
// field ports) carries one item for each complete header, raised by the LF
// of the CR LF CR LF terminator, or an item with o_header_overlong set when
// HEADER_LIMIT bytes pass without a terminator.
// A byte is registered on acceptance and scanned from that register. One
// byte per cycle is sustained unless the receiver stalls; the scanner state
// update is a single registered pass. If the receiver stalls, the result
// stays in the output register and the input register still takes one more
// byte before o_ready drops. Reset clears the scanner, empties both
// registers and loads the register defaults (expected sequence 1, body
// limit 2048). The user writes registers through i_cfg_we, i_cfg_index and
// i_cfg_data only while no header is open; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "rtsp_response_header_parser_assert.svh"

module rtsp_response_header_parser
    import rrhp_pkg::*;
#(
    parameter int HEADER_LIMIT   = DEF_HEADER_LIMIT,
    parameter int SESSION_ID_CAP = DEF_SESSION_ID_CAP
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [BYTE_W-1:0]     i_byte_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [NUM_W-1:0]      o_status_code,
    output logic                  o_sequence_present,
    output logic                  o_sequence_match,
    output logic                  o_challenge_present,
    output logic                  o_session_present,
    output logic [SID_OUT_W-1:0]  o_session_id_length,
    output logic [NUM_W-1:0]      o_session_timeout,
    output logic                  o_length_present,
    output logic [NUM_W-1:0]      o_content_length,
    output logic                  o_length_too_large,
    output logic                  o_header_overlong
);

    localparam int CNT_W = $clog2(HEADER_LIMIT + 1);
    localparam int SID_W = $clog2(SESSION_ID_CAP);
    localparam logic [SID_W:0]   SID_MAX   = (SID_W + 1)'(SESSION_ID_CAP - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(HEADER_LIMIT);

    typedef enum logic [2:0] {
        PH_START,
        PH_TOKEN,
        PH_SPACES,
        PH_DIGITS,
        PH_IGNORE,
        PH_KEY,
        PH_LEAD,
        PH_VALUE
    } t_phase;

    typedef enum logic [1:0] {
        TERM_IDLE,
        TERM_CR,
        TERM_CRLF,
        TERM_CRLFCR
    } t_term;

    typedef struct packed {
        logic [NUM_W-1:0] status;
        logic             seq_p;
        logic [NUM_W-1:0] seq;
        logic             chal;
        logic             sess;
        logic [SID_W-1:0] sid;
        logic [NUM_W-1:0] tmo;
        logic             len_p;
        logic [NUM_W-1:0] clen;
    } t_fld;

    typedef struct packed {
        t_term              term;
        logic [CNT_W-1:0]   cnt;
        t_phase             phase;
        logic               first;
        logic [KEY_NUM-1:0] cand;
        logic [KPOS_W-1:0]  kpos;
        logic [NUM_W-1:0]   acc;
        logic [TM_W-1:0]    tmatch;
        logic [SID_W-1:0]   pend;
        t_fld               fld;
    } t_scan;

    function automatic logic [SID_W-1:0] cap_add(input logic [SID_W-1:0] a,
                                                 input logic [SID_W-1:0] b);
        logic [SID_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > SID_MAX) ? SID_MAX[SID_W-1:0] : sum[SID_W-1:0];
    endfunction

    function automatic t_scan end_line(input t_scan s_in);
        t_scan s;
        s        = s_in;
        s.phase  = PH_START;
        s.cand   = KEY_ALL;
        s.kpos   = '0;
        s.acc    = '0;
        s.tmatch = TM_SID;
        s.pend   = '0;
        return s;
    endfunction

    function automatic t_scan msg_reset();
        t_scan s;
        s       = '0;
        s.term  = TERM_IDLE;
        s.first = 1'b1;
        return end_line(s);
    endfunction

    function automatic t_scan session_char(input t_scan s_in, input logic [BYTE_W-1:0] c,
                                           input logic [NUM_W-1:0] acc_nx);
        t_scan      s;
        logic [2:0] k;
        s = s_in;
        k = s.tmatch[2:0] - 3'd1;
        if (s.tmatch == TM_SID) begin
            if (c == CH_SEMI) begin
                s.fld.sid = cap_add(s.fld.sid, s.pend);
                s.pend    = '0;
                s.tmatch  = TM_SCAN;
            end else if (c == CH_SP || c == CH_TAB) begin
                s.pend = cap_add(s.pend, SID_W'(1));
            end else begin
                s.fld.sid = cap_add(s.fld.sid, cap_add(s.pend, SID_W'(1)));
                s.pend    = '0;
            end
        end else if (s.tmatch < TM_DIGITS) begin
            if (c == tmo_char(k)) begin
                if (s.tmatch == TM_DIGITS - 4'd1) begin
                    s.tmatch  = TM_DIGITS;
                    s.acc     = '0;
                    s.fld.tmo = '0;
                end else begin
                    s.tmatch = s.tmatch + 4'd1;
                end
            end else if (s.tmatch == TM_DIGITS - 4'd1 && c == CH_LC_I) begin
                s.tmatch = TM_SCAN + 4'd2;
            end else begin
                s.tmatch = (c == CH_LC_T) ? TM_SCAN + 4'd1 : TM_SCAN;
            end
        end else if (s.tmatch == TM_DIGITS) begin
            if (is_digit(c)) begin
                s.acc     = acc_nx;
                s.fld.tmo = acc_nx;
            end else begin
                s.tmatch = TM_DONE;
            end
        end
        return s;
    endfunction

    function automatic t_scan key_colon(input t_scan s_in);
        t_scan              s;
        logic [KEY_NUM-1:0] win;
        s   = s_in;
        win = KEY_NONE;
        for (int i = 0; i < KEY_NUM; i++) begin
            if (s.cand[i] && key_len(2'(i)) == s.kpos) begin
                win[i] = 1'b1;
            end
        end
        s.cand  = win;
        s.acc   = '0;
        s.phase = PH_LEAD;
        if (win == KEY_CSEQ) begin
            s.fld.seq_p = 1'b1;
            s.fld.seq   = '0;
        end else if (win == KEY_CLEN) begin
            s.fld.len_p = 1'b1;
            s.fld.clen  = '0;
        end else if (win == KEY_SESS) begin
            s.fld.sess = 1'b1;
            s.fld.sid  = '0;
            s.pend     = '0;
            s.tmatch   = TM_SID;
        end else if (win == KEY_AUTH) begin
            s.fld.chal = 1'b1;
            s.phase    = PH_IGNORE;
        end else begin
            s.phase = PH_IGNORE;
        end
        return s;
    endfunction

    function automatic t_scan feed(input t_scan s_in, input logic [BYTE_W-1:0] c);
        t_scan            s;
        logic [NUM_W-1:0] acc_nx;
        logic             dig;
        s = s_in;
        if (s.phase == PH_START) begin
            if (s.first) begin
                s.first = 1'b0;
                s.phase = PH_TOKEN;
            end else begin
                s.phase = PH_KEY;
                s.cand  = KEY_ALL;
                s.kpos  = '0;
            end
        end
        if (s.phase == PH_LEAD && c != CH_SP) begin
            s.phase = PH_VALUE;
        end
        acc_nx = acc_digit((s.phase == PH_SPACES) ? '0 : s.acc, c);
        dig    = is_digit(c);
        case (s.phase)
            PH_TOKEN: begin
                if (c == CH_SP) begin
                    s.phase = PH_SPACES;
                end
            end
            PH_SPACES, PH_DIGITS: begin
                if (dig) begin
                    s.acc        = acc_nx;
                    s.fld.status = acc_nx;
                    s.phase      = PH_DIGITS;
                end else if (!(c == CH_SP && s.phase == PH_SPACES)) begin
                    s.phase = PH_IGNORE;
                end
            end
            PH_KEY: begin
                if (c == CH_COLON) begin
                    s = key_colon(s);
                end else begin
                    for (int i = 0; i < KEY_NUM; i++) begin
                        if (s.kpos >= key_len(2'(i)) ||
                            to_lower(c) != key_char(2'(i), s.kpos[3:0])) begin
                            s.cand[i] = 1'b0;
                        end
                    end
                    if (s.kpos != '1) begin
                        s.kpos = s.kpos + 5'd1;
                    end
                end
            end
            PH_VALUE: begin
                if (s.cand == KEY_SESS) begin
                    s = session_char(s, c, acc_nx);
                end else if (dig) begin
                    s.acc = acc_nx;
                    if (s.cand == KEY_CSEQ) begin
                        s.fld.seq = acc_nx;
                    end else begin
                        s.fld.clen = acc_nx;
                    end
                end else begin
                    s.phase = PH_IGNORE;
                end
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    logic [EXP_SEQ_W-1:0]  r_exp_seq;
    logic [BODY_LIM_W-1:0] r_body_limit;
    logic                  r_in_vld;
    logic [BYTE_W-1:0]     r_byte;
    t_scan                 r_scan;
    t_scan                 n_scan;
    t_scan                 s_work;
    logic                  adv;
    logic                  prev_cr;
    logic                  done;
    logic                  overlong;
    logic                  n_emit;
    logic [CNT_W-1:0]      cnt_nx;

    logic                 r_out_vld;
    logic [NUM_W-1:0]     r_status, n_status;
    logic                 r_seq_p, n_seq_p;
    logic                 r_seq_m, n_seq_m;
    logic                 r_chal, n_chal;
    logic                 r_sess, n_sess;
    logic [SID_OUT_W-1:0] r_sid, n_sid;
    logic [NUM_W-1:0]     r_tmo, n_tmo;
    logic                 r_len_p, n_len_p;
    logic [NUM_W-1:0]     r_clen, n_clen;
    logic                 r_too_large, n_too_large;
    logic                 r_overlong, n_overlong;

    assign adv     = !r_out_vld || i_ready;
    assign o_ready = !r_in_vld || adv;

    always_comb begin
        prev_cr = r_scan.term == TERM_CR || r_scan.term == TERM_CRLFCR;
        cnt_nx  = r_scan.cnt + 1'b1;
        done    = 1'b0;
        s_work  = r_scan;
        if (r_byte == CH_LF) begin
            done        = r_scan.term == TERM_CRLFCR;
            s_work      = end_line(r_scan);
            s_work.term = (r_scan.term == TERM_CR) ? TERM_CRLF : TERM_IDLE;
        end else begin
            if (prev_cr) begin
                s_work = feed(s_work, CH_CR);
            end
            if (r_byte == CH_CR) begin
                s_work.term = (r_scan.term == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
            end else begin
                s_work.term = TERM_IDLE;
                s_work      = feed(s_work, r_byte);
            end
        end
        s_work.cnt = cnt_nx;
        overlong   = !done && cnt_nx == CNT_LIMIT;
        n_emit     = done || overlong;
        n_scan     = n_emit ? msg_reset() : s_work;

        n_status    = r_scan.fld.status;
        n_seq_p     = r_scan.fld.seq_p;
        n_seq_m     = r_scan.fld.seq_p && r_scan.fld.seq == {1'b0, r_exp_seq};
        n_chal      = r_scan.fld.chal;
        n_sess      = r_scan.fld.sess;
        n_sid       = SID_OUT_W'(r_scan.fld.sid);
        n_tmo       = r_scan.fld.tmo;
        n_len_p     = r_scan.fld.len_p;
        n_clen      = r_scan.fld.clen;
        n_too_large = r_scan.fld.len_p && r_scan.fld.clen > {16'd0, r_body_limit};
        n_overlong  = 1'b0;
        if (overlong) begin
            n_status    = '0;
            n_seq_p     = 1'b0;
            n_seq_m     = 1'b0;
            n_chal      = 1'b0;
            n_sess      = 1'b0;
            n_sid       = '0;
            n_tmo       = '0;
            n_len_p     = 1'b0;
            n_clen      = '0;
            n_too_large = 1'b0;
            n_overlong  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_seq    <= EXP_SEQ_RST;
            r_body_limit <= BODY_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPECTED_SEQUENCE: r_exp_seq <= i_cfg_data[EXP_SEQ_W-1:0];
                CFG_BODY_LIMIT:        r_body_limit <= i_cfg_data[BODY_LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_scan    <= msg_reset();
        end else begin
            if (i_valid && o_ready) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= r_in_vld && n_emit;
            end
            if (r_in_vld && adv) begin
                r_scan <= n_scan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte_in;
        end
        if (r_in_vld && adv && n_emit) begin
            r_status    <= n_status;
            r_seq_p     <= n_seq_p;
            r_seq_m     <= n_seq_m;
            r_chal      <= n_chal;
            r_sess      <= n_sess;
            r_sid       <= n_sid;
            r_tmo       <= n_tmo;
            r_len_p     <= n_len_p;
            r_clen      <= n_clen;
            r_too_large <= n_too_large;
            r_overlong  <= n_overlong;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_status_code       = r_status;
    assign o_sequence_present  = r_seq_p;
    assign o_sequence_match    = r_seq_m;
    assign o_challenge_present = r_chal;
    assign o_session_present   = r_sess;
    assign o_session_id_length = r_sid;
    assign o_session_timeout   = r_tmo;
    assign o_length_present    = r_len_p;
    assign o_content_length    = r_clen;
    assign o_length_too_large  = r_too_large;
    assign o_header_overlong   = r_overlong;

    `RRHP_ASSERT_IMPLY(a_cnt_below_limit, 1'b1, r_scan.cnt < CNT_LIMIT)
    `RRHP_ASSERT_IMPLY(a_overlong_clean, o_valid && o_header_overlong, o_status_code == 32'd0 && !o_sequence_present && !o_session_present && !o_length_present && o_content_length == 32'd0)
    `RRHP_ASSERT_IMPLY(a_flags_consistent, o_valid, (!o_sequence_match || o_sequence_present) && (!o_length_too_large || o_length_present))
    `RRHP_ASSERT_NEXT(a_emit_restarts, r_in_vld && adv && n_emit, o_valid && r_scan.first && r_scan.cnt == '0)

endmodule

>>> verif/tb_rtsp_response_header_parser.sv
// ----------------------------------------------------------------------------
// RTSP response header parser testbench
// Streams directed and random RTSP response headers, one byte per item, into
// the parser. Random idle gaps and a long receiver stall are applied. Every
// result item is checked field by field against a scanner model kept inside
// this bench, across several register settings.
// ----------------------------------------------------------------------------
module tb_rtsp_response_header_parser;
    import rrhp_pkg::*;

    localparam int LONG_HOLD = 400;

    typedef enum logic [2:0] {
        LN_START, LN_TOKEN, LN_SPACES, LN_DIGITS, LN_IGNORE, LN_KEY, LN_LEAD, LN_VALUE
    } line_state_e;

    typedef struct {
        logic [NUM_W-1:0] status;
        logic             seq_seen;
        logic [NUM_W-1:0] seq;
        logic             chal;
        logic             sess;
        int               sid_len;
        logic [NUM_W-1:0] tmo;
        logic             len_seen;
        logic [NUM_W-1:0] clen;
    } header_fields_t;

    typedef struct {
        logic [NUM_W-1:0]     status_code;
        logic                 sequence_present;
        logic                 sequence_match;
        logic                 challenge_present;
        logic                 session_present;
        logic [SID_OUT_W-1:0] session_id_length;
        logic [NUM_W-1:0]     session_timeout;
        logic                 length_present;
        logic [NUM_W-1:0]     content_length;
        logic                 length_too_large;
        logic                 header_overlong;
    } header_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_EXPECTED_SEQUENCE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [BYTE_W-1:0]     i_byte_in = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [NUM_W-1:0]      o_status_code;
    logic                  o_sequence_present;
    logic                  o_sequence_match;
    logic                  o_challenge_present;
    logic                  o_session_present;
    logic [SID_OUT_W-1:0]  o_session_id_length;
    logic [NUM_W-1:0]      o_session_timeout;
    logic                  o_length_present;
    logic [NUM_W-1:0]      o_content_length;
    logic                  o_length_too_large;
    logic                  o_header_overlong;

    rtsp_response_header_parser uut (.*);

    // Scanner model state and its copy of the registers.
    logic [EXP_SEQ_W-1:0]  want_seq = EXP_SEQ_RST;
    logic [BODY_LIM_W-1:0] body_max = BODY_LIMIT_RST;
    int                    crlf_run = 0;
    int                    hdr_bytes = 0;
    line_state_e           line_st = LN_START;
    logic                  status_line_next = 1'b1;
    logic [KEY_NUM-1:0]    key_alive = KEY_ALL;
    int                    key_pos = 0;
    logic [NUM_W-1:0]      num_acc = '0;
    logic [TM_W-1:0]       tmo_st = TM_SID;
    int                    ws_run = 0;
    header_fields_t        hdr = '{default: 0};
    string key_name [KEY_NUM] = '{"cseq", "www-authenticate", "session", "content-length"};
    string tmo_word = "timeout=";

    logic [BYTE_W-1:0] byte_queue [$];
    header_result_t    parsed_headers [$];
    int                bytes_queued = 0;
    int                err_count = 0;
    bit                idle_on = 1'b1;
    int                send_gap = 0;
    int                recv_gap = 0;
    int                hold_ticket = 0;
    int                hold_done = 0;
    int                hold_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [NUM_W-1:0] append_decimal(input logic [NUM_W-1:0] a,
                                                        input logic [BYTE_W-1:0] c);
        logic [NUM_W+3:0] v;
        v = {4'd0, a} * 36'd10 + {28'd0, c} - 36'd48;
        return (v > 36'hFFFF_FFFF) ? '1 : v[NUM_W-1:0];
    endfunction

    function automatic bit is_dec(input logic [BYTE_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int sid_cap(input int a, input int b);
        return (a + b > DEF_SESSION_ID_CAP - 1) ? DEF_SESSION_ID_CAP - 1 : a + b;
    endfunction

    function automatic void clear_line();
        line_st = LN_START;
        key_alive = KEY_ALL;
        key_pos = 0;
        num_acc = '0;
        tmo_st = TM_SID;
        ws_run = 0;
    endfunction

    function automatic void restart_header();
        crlf_run = 0;
        hdr_bytes = 0;
        status_line_next = 1'b1;
        hdr = '{default: 0};
        clear_line();
    endfunction

    function automatic void scan_char(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0]  lc;
        logic [KEY_NUM-1:0] win;
        int                 k;
        if (line_st == LN_START) begin
            if (status_line_next) begin
                status_line_next = 1'b0;
                line_st = LN_TOKEN;
            end else begin
                line_st = LN_KEY;
                key_alive = KEY_ALL;
                key_pos = 0;
            end
        end
        if (line_st == LN_LEAD) begin
            if (c == " ")
                return;
            line_st = LN_VALUE;
        end
        case (line_st)
            LN_TOKEN: begin
                if (c == " ")
                    line_st = LN_SPACES;
            end
            LN_SPACES, LN_DIGITS: begin
                if (is_dec(c)) begin
                    if (line_st == LN_SPACES)
                        num_acc = '0;
                    num_acc = append_decimal(num_acc, c);
                    hdr.status = num_acc;
                    line_st = LN_DIGITS;
                end else if (!(c == " " && line_st == LN_SPACES)) begin
                    line_st = LN_IGNORE;
                end
            end
            LN_KEY: begin
                if (c == ":") begin
                    win = KEY_NONE;
                    for (int i = 0; i < KEY_NUM; i++)
                        if (key_alive[i] && key_name[i].len() == key_pos) begin
                            win = KEY_NONE;
                            win[i] = 1'b1;
                        end
                    key_alive = win;
                    num_acc = '0;
                    line_st = LN_LEAD;
                    if (win == KEY_CSEQ) begin
                        hdr.seq_seen = 1'b1;
                        hdr.seq = '0;
                    end else if (win == KEY_CLEN) begin
                        hdr.len_seen = 1'b1;
                        hdr.clen = '0;
                    end else if (win == KEY_SESS) begin
                        hdr.sess = 1'b1;
                        hdr.sid_len = 0;
                        ws_run = 0;
                        tmo_st = TM_SID;
                    end else begin
                        if (win == KEY_AUTH)
                            hdr.chal = 1'b1;
                        line_st = LN_IGNORE;
                    end
                end else begin
                    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                    for (int i = 0; i < KEY_NUM; i++)
                        if (key_pos >= key_name[i].len() || lc != key_name[i][key_pos])
                            key_alive[i] = 1'b0;
                    if (key_pos < 31)
                        key_pos++;
                end
            end
            LN_VALUE: begin
                if (key_alive == KEY_SESS) begin
                    if (tmo_st == TM_SID) begin
                        if (c == ";") begin
                            hdr.sid_len = sid_cap(hdr.sid_len, ws_run);
                            ws_run = 0;
                            tmo_st = TM_SCAN;
                        end else if (c == " " || c == "\t") begin
                            ws_run = sid_cap(ws_run, 1);
                        end else begin
                            hdr.sid_len = sid_cap(hdr.sid_len, sid_cap(ws_run, 1));
                            ws_run = 0;
                        end
                    end else if (tmo_st < TM_DIGITS) begin
                        k = int'(tmo_st) - 1;
                        if (c == tmo_word[k]) begin
                            if (k == 7) begin
                                tmo_st = TM_DIGITS;
                                num_acc = '0;
                                hdr.tmo = '0;
                            end else begin
                                tmo_st = k + 2;
                            end
                        end else if (k == 7 && c == "i") begin
                            tmo_st = TM_SCAN + 2;
                        end else begin
                            tmo_st = (c == "t") ? TM_SCAN + 1 : TM_SCAN;
                        end
                    end else if (tmo_st == TM_DIGITS) begin
                        if (is_dec(c)) begin
                            num_acc = append_decimal(num_acc, c);
                            hdr.tmo = num_acc;
                        end else begin
                            tmo_st = TM_DONE;
                        end
                    end
                end else if (is_dec(c)) begin
                    num_acc = append_decimal(num_acc, c);
                    if (key_alive == KEY_CSEQ)
                        hdr.seq = num_acc;
                    else
                        hdr.clen = num_acc;
                end else begin
                    line_st = LN_IGNORE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void parse_byte(input logic [BYTE_W-1:0] c);
        header_result_t r;
        bit             prev_cr;
        bit             done;
        prev_cr = (crlf_run == 1 || crlf_run == 3);
        done = 1'b0;
        hdr_bytes++;
        if (c == CH_LF) begin
            done = (crlf_run == 3);
            crlf_run = (crlf_run == 1) ? 2 : 0;
            clear_line();
        end else begin
            if (prev_cr)
                scan_char(CH_CR);
            if (c == CH_CR) begin
                crlf_run = (crlf_run == 2) ? 3 : 1;
            end else begin
                crlf_run = 0;
                scan_char(c);
            end
        end
        r = '{default: 0};
        if (done) begin
            r.status_code = hdr.status;
            r.sequence_present = hdr.seq_seen;
            r.sequence_match = hdr.seq_seen && hdr.seq == {1'b0, want_seq};
            r.challenge_present = hdr.chal;
            r.session_present = hdr.sess;
            r.session_id_length = hdr.sid_len[SID_OUT_W-1:0];
            r.session_timeout = hdr.tmo;
            r.length_present = hdr.len_seen;
            r.content_length = hdr.clen;
            r.length_too_large = hdr.len_seen && hdr.clen > {16'd0, body_max};
            parsed_headers.push_back(r);
            restart_header();
        end else if (hdr_bytes >= DEF_HEADER_LIMIT) begin
            r.header_overlong = 1'b1;
            parsed_headers.push_back(r);
            restart_header();
        end
    endfunction

    function automatic int idle_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && o_ready)
                parse_byte(i_byte_in);
            if (!i_valid || o_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    i_valid <= 1'b1;
                    i_byte_in <= byte_queue.pop_front();
                    send_gap <= idle_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [NUM_W-1:0] got,
                               input logic [NUM_W-1:0] want);
        if (got !== want) begin
            err_count++;
            if (err_count <= 10)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic check_result();
        header_result_t want;
        if (parsed_headers.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("result item with none expected: status %0d, overlong %0b",
                         o_status_code, o_header_overlong);
        end else begin
            want = parsed_headers.pop_front();
            check_field("status_code", o_status_code, want.status_code);
            check_field("sequence_present", o_sequence_present, want.sequence_present);
            check_field("sequence_match", o_sequence_match, want.sequence_match);
            check_field("challenge_present", o_challenge_present, want.challenge_present);
            check_field("session_present", o_session_present, want.session_present);
            check_field("session_id_length", o_session_id_length, want.session_id_length);
            check_field("session_timeout", o_session_timeout, want.session_timeout);
            check_field("length_present", o_length_present, want.length_present);
            check_field("content_length", o_content_length, want.content_length);
            check_field("length_too_large", o_length_too_large, want.length_too_large);
            check_field("header_overlong", o_header_overlong, want.header_overlong);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
            hold_done <= 0;
        end else begin
            if (o_valid && i_ready)
                check_result();
            if (hold_done != hold_ticket) begin
                hold_done <= hold_ticket;
                hold_left <= LONG_HOLD;
                i_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (o_valid && i_ready)
                    recv_gap <= idle_gap();
            end
        end
    end

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            byte_queue.push_back(s[i]);
            bytes_queued++;
        end
    endtask

    task automatic put_noise(input int n, input bit keep_line);
        logic [BYTE_W-1:0] b;
        repeat (n) begin
            b = $urandom_range(0, 255);
            if (keep_line && b == CH_LF)
                b = CH_SP;
            byte_queue.push_back(b);
            bytes_queued++;
        end
    endtask

    function automatic string spaces(input int n);
        string s;
        s = "";
        repeat (n) s = {s, " "};
        return s;
    endfunction

    function automatic int digit_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r < 14)
            return $urandom_range(1, 4);
        if (r < 17)
            return $urandom_range(5, 9);
        return $urandom_range(10, 12);
    endfunction

    function automatic string rand_digits(input int n);
        string s;
        s = "";
        repeat (n) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        return s;
    endfunction

    function automatic string rand_word(input int n);
        string s;
        int    r;
        byte   ch;
        s = "";
        repeat (n) begin
            r = $urandom_range(0, 61);
            ch = (r < 10) ? 8'h30 + r : (r < 36) ? 8'h41 + r - 10 : 8'h61 + r - 36;
            s = $sformatf("%s%c", s, ch);
        end
        return s;
    endfunction

    function automatic string mix_case(input string s);
        string r;
        byte   ch;
        r = s;
        for (int i = 0; i < r.len(); i++) begin
            ch = r[i];
            if (ch >= "a" && ch <= "z" && $urandom_range(0, 1))
                r[i] = ch - 32;
            else if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1))
                r[i] = ch + 32;
        end
        return r;
    endfunction

    function automatic string mangle_key(input string k);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return k.substr(0, k.len() - 2);
        if (r == 1)
            return {k, "x"};
        if (r == 2)
            return {k, " "};
        return mix_case(k);
    endfunction

    function automatic string value_lead();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return ":\t";
        return {":", spaces($urandom_range(0, 2))};
    endfunction

    task automatic put_session_line();
        int    r;
        int    id_len;
        string s;
        r = $urandom_range(0, 9);
        id_len = (r < 7) ? $urandom_range(0, 20) :
                 (r < 9) ? $urandom_range(21, 62) : $urandom_range(63, 80);
        s = {mangle_key("Session"), value_lead(), rand_word(id_len)};
        if ($urandom_range(0, 5) == 0)
            s = {s, " ", rand_word(3)};
        case ($urandom_range(0, 3))
            0: s = {s, " "};
            1: s = {s, "\t"};
            2: s = {s, " \t "};
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2: s = {s, ";timeout=", rand_digits(digit_count())};
            3: s = {s, ";ttimeout=", rand_digits(digit_count())};
            4: s = {s, ";x=1;timeout=", rand_digits(digit_count()), ";y"};
            5: s = {s, ";timeouti", rand_digits(2), "timeout=", rand_digits(3)};
            6: s = {s, ";Timeout=", rand_digits(2)};
            default: ;
        endcase
        put_text({s, "\r\n"});
    endtask

    task automatic put_random_header();
        int    val;
        string s;
        if ($urandom_range(0, 9) == 0)
            put_text("\n");
        if ($urandom_range(0, 15) == 0) begin
            put_noise($urandom_range(1, 20), 1'b1);
            put_text("\r\n");
        end else begin
            case ($urandom_range(0, 3))
                0: s = "RTSP/1.0";
                1: s = "rtsp/2.0";
                2: s = "R2D2/1";
                default: s = "RTSP/1.0";
            endcase
            s = {s, spaces($urandom_range(0, 3))};
            if ($urandom_range(0, 3) != 0)
                s = $sformatf("%s%0d", s, $urandom_range(100, 599));
            else
                s = {s, rand_digits(digit_count())};
            if ($urandom_range(0, 1))
                s = {s, " ", rand_word($urandom_range(1, 8))};
            put_text({s, "\r\n"});
        end
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 11))
                0, 1: begin
                    if ($urandom_range(0, 1))
                        s = $sformatf("%0d", want_seq);
                    else
                        s = rand_digits(digit_count());
                    put_text({mangle_key("CSeq"), value_lead(), s, "\r\n"});
                end
                2, 3: begin
                    if ($urandom_range(0, 4) < 2) begin
                        val = int'(body_max) + $urandom_range(0, 2) - 1;
                        s = $sformatf("%0d", (val < 0) ? 0 : val);
                    end else begin
                        s = rand_digits(digit_count());
                    end
                    if ($urandom_range(0, 7) == 0)
                        s = {s, "\r9"};
                    put_text({mangle_key("Content-Length"), value_lead(), s, "\r\n"});
                end
                4, 5: put_session_line();
                6: put_text({mangle_key("WWW-Authenticate"), ": Digest realm=\"",
                             rand_word(6), "\", nonce=\"", rand_word(12), "\"\r\n"});
                7: put_text({"Server", value_lead(), rand_word(5), "\r\n"});
                8: put_text({rand_word($urandom_range(1, 10)), "\r\n"});
                9: put_text({"C Seq: ", rand_digits(2), "\r\n"});
                default: begin
                    put_noise($urandom_range(1, 30), 1'b1);
                    put_text("\r\n");
                end
            endcase
        end
        if ($urandom_range(0, 11) != 0)
            put_text("\r\n");
    endtask

    // Waits until every byte is in and every result has arrived, then lets the
    // pipeline run dry. A half-open header is closed off with extra line ends.
    task automatic settle();
        do begin
            do @(negedge i_clk);
            while (byte_queue.size() != 0 || i_valid || parsed_headers.size() != 0);
            repeat (8) @(negedge i_clk);
            if (hdr_bytes != 0)
                put_text("\r\n");
        end while (hdr_bytes != 0);
    endtask

    task automatic configure(input logic [EXP_SEQ_W-1:0] seq, input logic [BODY_LIM_W-1:0] lim);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_EXPECTED_SEQUENCE;
        i_cfg_data <= seq;
        @(posedge i_clk);
        i_cfg_index <= CFG_BODY_LIMIT;
        i_cfg_data <= {{(CFG_DATA_W - BODY_LIM_W){1'b0}}, lim};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        want_seq = seq;
        body_max = lim;
    endtask

    initial begin
        int made;
        int start;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put_text("RTSP/1.0 200 OK\r\nCSeq: 1\r\nContent-Length: 0\r\n\r\n");
        put_text("\r\n\r\n");
        put_text("\nRTSP/1.0 404 Not Found\r\ncseq: 2\r\n\r\n");
        put_text("RTSP/1.0 OK\r\nCONTENT-LENGTH: 2049\r\n\r\n");
        put_text("RTSP/1.0 99999999999\r\ncontent-length: 2048\r\n\r\n");
        put_text("RTSP/1.0 4294967295\r\nContent-Length: 4294967296\r\n");
        put_text("CSeq: 4294967295\r\n\r\n");
        put_text("RTSP/1.0 200 OK\r\nSession: 12345678;timeout=60\r\n\r\n");
        put_text("RTSP/1.0 200 OK\r\nSession:   abc \t \r\n\r\n");
        put_text({"RTSP/1.0 200 OK\r\nSession: ", rand_word(70), "\r\n\r\n"});
        put_text("RTSP/1.0 200 OK\r\nSession: x;timeout=99999999999\r\nSession: y\r\n\r\n");
        put_text("RTSP/1.0 200 OK\r\nSession: a ;ttimeout=5\r\n\r\n");
        put_text("RTSP/1.0 200 OK\r\nSession: a;timeouti=7;timeout=8\r\n\r\n");
        put_text("RTSP/1.0 200 OK\r\nSession: b;Timeout=9;timeout=\r\n\r\n");
        put_text("RTSP/1.0 401 Unauthorized\r\nWWW-Authenticate: Digest realm=\"x\"\r\n\r\n");
        put_text("RTSP/1.0 200 OK\r\nCSeq : 5\r\nServer: x\r\ngarbage line\r\n\r\n");
        put_text("RTSP/1.0 200 OK\r\nCSeq: 3\r\nCSeq: 1\r\nContent-Length: 10\r\n");
        put_text("Content-Length: 9999\r\n\r\n");
        put_text("RTSP/1.0 200 OK\r\nCSeq: 1\r2\r\nContent-Length:\t12\r\n\r\n");
        put_text("RTSP1 R 200\r\n\r\nR2D2/1.0  200 OK\r\n\r\nRTSP/1.0 201\r\n\r\n");
        put_text("RTSP/1.0 200 OK\r\nX: ");
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h80);
        byte_queue.push_back(8'h7F);
        put_text("\r\n\r\n");
        // A header that never ends is cut off at the byte limit.
        put_text("RTSP/1.0 200 OK\r\n");
        repeat (1600) put_text("x");
        put_text("\r\n\r\n");
        settle();

        for (int step_no = 0; step_no < 5; step_no++) begin
            case (step_no)
                0: configure('0, '0);
                1: configure('1, '1);
                default: configure($urandom_range(0, 500), $urandom_range(0, 65535));
            endcase
            idle_on = (step_no != 2);
            made = 0;
            start = bytes_queued;
            while (made < 14 || bytes_queued - start < 200) begin
                put_random_header();
                made++;
            end
            if (step_no == 3) begin
                put_noise(1600, 1'b0);
                put_text("\r\n\r\n");
            end
            if (step_no == 1) begin
                @(negedge i_clk);
                hold_ticket = hold_ticket + 1;
            end
            settle();
        end

        if (err_count == 0)
            $display("rtsp_response_header_parser regression: pass");
        else
            $display("rtsp_response_header_parser regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("rtsp_response_header_parser regression: fail");
        $finish;
    end

endmodule
